@@ rtl/qrst_pkg.sv @@
// Package for the queued relay step timer: constants, codes and shared types.
// No dependencies.
`default_nettype none
package qrst_pkg;
    localparam int MaxSteps = 16;
    localparam int IdxW = $clog2(MaxSteps);
    localparam int CntW = $clog2(MaxSteps + 1);
    localparam logic [7:0] SupportedChannel = 8'd1;
    localparam int ResultCap = 16;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_TOGGLE = 3'd3;
    localparam logic [2:0] CMD_CHANGE = 3'd4;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_BAD_CHAN = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_DUP      = 3'd3;
    localparam logic [2:0] STS_EMPTY    = 3'd4;
    localparam logic [2:0] STS_PROT     = 3'd5;

    localparam logic [2:0] RS_IDLE  = 3'd0;
    localparam logic [2:0] RS_RUN   = 3'd1;
    localparam logic [2:0] RS_PAUSE = 3'd2;
    localparam logic [2:0] RS_OVP   = 3'd3;
    localparam logic [2:0] RS_OCP   = 3'd4;
    localparam logic [2:0] RS_OVR   = 3'd5;

    localparam logic [1:0] CAUSE_OVP   = 2'd0;
    localparam logic [1:0] CAUSE_OCP   = 2'd1;
    localparam logic [1:0] CAUSE_OVR   = 2'd2;
    localparam logic [1:0] CAUSE_TIMER = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  channel;
        logic [23:0] step_id;
        logic [31:0] step_duration_ms;
        logic        step_relay_on;
        logic [1:0]  change_cause;
        logic        protection_clear_ok;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status_code;
        logic        relay_cmd_valid;
        logic        relay_on;
        logic [23:0] expired_id;
        logic [2:0]  timer_state;
        logic [23:0] head_id;
        logic        queue_empty;
        logic [31:0] time_left_ms;
        logic [4:0]  queue_count;
        logic        last;
    } t_out_beat;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;        // capture input beat
        logic scan_clr;    // reset duplicate search
        logic scan_step;   // compare one entry
        logic act;         // apply command action
        logic expire;      // pop head and load next
        logic emit;        // build result beat
        logic emit_exp;    // result is an expiry
        logic emit_last;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic due;
        logic plain;       // command ends with one status result only
        logic is_add;
    } t_dp_sts;
endpackage
`default_nettype wire

@@ rtl/qrst_if.sv @@
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface qrst_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/qrst_datapath.sv @@
// Datapath: step queue, run state, countdown and result formation.
// Depends on qrst_pkg.
`default_nettype none
module qrst_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire qrst_pkg::t_in_beat i_beat,
    input  wire qrst_pkg::t_dp_cmd  i_cmd,
    output qrst_pkg::t_dp_sts       o_sts,
    output qrst_pkg::t_out_beat     o_res
);
    import qrst_pkg::*;

    logic [23:0] r_ids [MaxSteps];
    logic [31:0] r_durs [MaxSteps];
    logic        r_flags [MaxSteps];
    logic [CntW-1:0] r_count;
    logic [2:0]  r_state;
    logic [31:0] r_cd;
    t_in_beat    r_in;
    logic [CntW-1:0] r_scan;
    logic        r_dup;
    logic [2:0]  r_status;

    logic empty, full, chan_ok, known;
    logic [2:0] act_status;
    assign empty = (r_count == '0);
    assign full = (r_count >= CntW'(MaxSteps));
    assign chan_ok = (r_in.channel == SupportedChannel);
    assign known = (r_in.command <= CMD_CHANGE);

    assign o_sts.scan_done = (r_scan >= r_count) || r_dup;
    assign o_sts.due = (r_state == RS_RUN) && !empty && (r_cd == '0);
    assign o_sts.plain = !known || !chan_ok || (r_in.command == CMD_CLEAR);
    assign o_sts.is_add = (r_in.command == CMD_ADD) && !full;

    // Status of the captured command; unknown commands report ok.
    always_comb begin
        act_status = STS_OK;
        if (known && !chan_ok) act_status = STS_BAD_CHAN;
        else if (r_in.command == CMD_ADD && full) act_status = STS_FULL;
        else if (r_in.command == CMD_ADD && r_dup) act_status = STS_DUP;
        else if (r_in.command == CMD_TOGGLE && empty) act_status = STS_EMPTY;
        else if (r_in.command == CMD_TOGGLE && r_state != RS_RUN
                 && (r_state == RS_OVP || r_state == RS_OCP)
                 && !r_in.protection_clear_ok) act_status = STS_PROT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_state <= RS_IDLE;
            r_cd <= '0;
        end else begin
            if (i_cmd.load) begin
                r_in <= i_beat;
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
                r_dup <= 1'b0;
            end else if (i_cmd.scan_step && !o_sts.scan_done) begin
                if (r_ids[r_scan[IdxW-1:0]] == r_in.step_id) begin
                    r_dup <= 1'b1;
                end
                r_scan <= r_scan + CntW'(1);
            end
            if (i_cmd.act) begin
                r_status <= act_status;
                if (known && chan_ok) begin
                    unique case (r_in.command)
                        CMD_TICK: begin
                            if (r_state == RS_RUN && !empty && r_cd != '0) begin
                                r_cd <= r_cd - 32'd1;
                            end
                        end
                        CMD_ADD: begin
                            if (act_status == STS_OK) begin
                                r_ids[r_count[IdxW-1:0]] <= r_in.step_id;
                                r_durs[r_count[IdxW-1:0]] <= r_in.step_duration_ms;
                                r_flags[r_count[IdxW-1:0]] <= r_in.step_relay_on;
                                r_count <= r_count + CntW'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            r_count <= '0;
                            r_state <= RS_IDLE;
                            r_cd <= '0;
                        end
                        CMD_TOGGLE: begin
                            if (act_status == STS_OK) begin
                                if (r_state == RS_RUN) begin
                                    r_state <= RS_PAUSE;
                                end else begin
                                    if (r_state == RS_IDLE) begin
                                        r_cd <= r_durs[0];
                                    end
                                    r_state <= RS_RUN;
                                end
                            end
                        end
                        default: begin
                            if (r_in.change_cause != CAUSE_TIMER && r_state == RS_RUN
                                && !empty) begin
                                r_state <= (r_in.change_cause == CAUSE_OVP) ? RS_OVP :
                                           (r_in.change_cause == CAUSE_OCP) ? RS_OCP :
                                           RS_OVR;
                            end
                        end
                    endcase
                end
            end
            if (i_cmd.expire) begin
                o_res.expired_id <= r_ids[0];
                o_res.relay_on <= r_flags[0];
                for (int i = 0; i < MaxSteps - 1; i++) begin
                    r_ids[i] <= r_ids[i+1];
                    r_durs[i] <= r_durs[i+1];
                    r_flags[i] <= r_flags[i+1];
                end
                r_count <= r_count - CntW'(1);
                if (r_count == CntW'(1)) begin
                    r_state <= RS_IDLE;
                    r_cd <= '0;
                end else begin
                    r_cd <= r_durs[1];
                end
            end
            if (i_cmd.emit) begin
                o_res.status_code <= i_cmd.emit_exp ? STS_OK : r_status;
                o_res.relay_cmd_valid <= i_cmd.emit_exp ||
                    (known && chan_ok && r_in.command == CMD_CLEAR);
                if (!i_cmd.emit_exp) begin
                    o_res.relay_on <= 1'b0;
                    o_res.expired_id <= '0;
                end
                o_res.timer_state <= empty ? RS_IDLE : r_state;
                o_res.head_id <= empty ? 24'd0 : r_ids[0];
                o_res.queue_empty <= empty;
                o_res.time_left_ms <= empty ? 32'd0 :
                                      (r_state == RS_IDLE) ? r_durs[0] : r_cd;
                o_res.queue_count <= 5'(r_count);
                o_res.last <= i_cmd.emit_last;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/qrst_ctrl.sv @@
// Controller: sequences search, action, expiries and result beats.
// Depends on qrst_pkg.
`default_nettype none
module qrst_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire qrst_pkg::t_dp_sts i_sts,
    output qrst_pkg::t_dp_cmd      o_cmd
);
    import qrst_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_CHECK, S_EXP, S_EMIT, S_OUT}
        t_state;
    t_state r_st;
    logic [4:0] r_nexp;
    logic       r_last;
    logic       r_final;

    assign o_in_ready = (r_st == S_IDLE);

    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_st == S_IDLE) && i_in_valid;
        o_cmd.scan_clr = o_cmd.load;
        o_cmd.scan_step = (r_st == S_SCAN);
        o_cmd.act = (r_st == S_ACT);
        o_cmd.expire = (r_st == S_EXP);
        o_cmd.emit = (r_st == S_EMIT);
        o_cmd.emit_exp = (r_st == S_EMIT) && (r_nexp != '0);
        // The pop has already happened here, so due tells whether another follows.
        o_cmd.emit_last = r_final || !i_sts.due || (r_nexp >= 5'(ResultCap));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            o_out_valid <= 1'b0;
            r_nexp <= '0;
            r_last <= 1'b0;
            r_final <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: if (i_in_valid) begin
                    r_st <= S_SCAN;
                    r_nexp <= '0;
                end
                S_SCAN: if (!i_sts.is_add || i_sts.scan_done) r_st <= S_ACT;
                S_ACT: r_st <= S_CHECK;
                S_CHECK: begin
                    if (!i_sts.plain && i_sts.due && r_nexp < 5'(ResultCap)) begin
                        r_st <= S_EXP;
                    end else if (r_nexp == '0) begin
                        r_final <= 1'b1;
                        r_st <= S_EMIT;
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                S_EXP: begin
                    r_nexp <= r_nexp + 5'd1;
                    r_st <= S_EMIT;
                    r_final <= 1'b0;
                end
                S_EMIT: begin
                    r_st <= S_OUT;
                    o_out_valid <= 1'b0;
                end
                default: begin
                    // Hold the beat; for expiries, decide whether it is the last
                    // by checking the next due condition before release.
                    if (!o_out_valid) begin
                        if (r_final || !i_sts.due || r_nexp >= 5'(ResultCap)) begin
                            r_last <= 1'b1;
                        end else begin
                            r_last <= 1'b0;
                        end
                        o_out_valid <= 1'b1;
                    end else if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        r_final <= 1'b0;
                        r_st <= r_last ? S_IDLE : S_EXP;
                    end
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input taken while a result is pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nexp <= 5'(ResultCap))
        else $error("expiry count exceeds cap");
endmodule
`default_nettype wire

@@ rtl/queued_relay_step_timer.sv @@
// Top level of the queued relay step timer.
// Depends on qrst_pkg, qrst_if, qrst_ctrl and qrst_datapath.
//
// One input channel carries command beats (tick, add, clear, toggle, output
// change); one output channel carries result beats, the final one of each
// command flagged by last. A command is taken only when the previous one has
// delivered all of its results. An add step searches the queue one entry a
// cycle for a duplicate of its step id, and up to sixteen expiries follow
// one command. The result beat sits in a register and holds while the
// receiver stalls; no further work proceeds until it is taken.
// Reset empties the queue, sets the timer idle and clears the countdown;
// queue entries themselves are not cleared since entries beyond the count
// are never read.
`default_nettype none
module queued_relay_step_timer (
    input wire logic i_clk,
    input wire logic i_rst_n,
    qrst_if.sink     i_cmd,
    qrst_if.source   o_res
);
    import qrst_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    qrst_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_cmd.valid), .o_in_ready(i_cmd.ready),
        .o_out_valid(o_res.valid), .i_out_ready(o_res.ready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    qrst_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_beat(i_cmd.data), .i_cmd(w_cmd), .o_sts(w_sts), .o_res(o_res.data)
    );
endmodule
`default_nettype wire
